// File: rtl/core/hcss_pkg.sv
`default_nettype none

package hcss_pkg;

    // field widths
    localparam int FUND_W     = 20;
    localparam int BIN_W      = 9;
    localparam int VAL_W      = 24;
    localparam int MASK_W     = 16;
    localparam int SR_W       = 18;
    localparam int WR_W       = 16;
    localparam int QUOT_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // Nyquist in 1/16 Hz is sample_rate * 8
    localparam int NYQ_W  = SR_W + 3;
    // harmonic frequency h * fund, one add past Nyquist at most
    localparam int HF_W   = NYQ_W + 1;
    // bin frequency bin * sample_rate * 16
    localparam int BNUM_W = BIN_W + SR_W + 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_RATIO = 2'd1;

    localparam logic [SR_W-1:0]   SAMPLE_RATE_RESET = 18'd48000;
    localparam logic [WR_W-1:0]   WIDTH_RATIO_RESET = 16'd3277;
    localparam logic [MASK_W-1:0] MASK_ONE          = 16'd32768;

    typedef struct packed {
        logic        [FUND_W-1:0] fundamental;
        logic        [BIN_W-1:0]  bin_index;
        logic signed [VAL_W-1:0]  bin_re;
        logic signed [VAL_W-1:0]  bin_im;
    } hcss_in_t;

    typedef struct packed {
        logic        [MASK_W-1:0] mask;
        logic signed [VAL_W-1:0]  harm_re;
        logic signed [VAL_W-1:0]  harm_im;
        logic signed [VAL_W-1:0]  rest_re;
        logic signed [VAL_W-1:0]  rest_im;
    } hcss_out_t;

    // floor square root, elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        int          i;
        x = x_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // weight of harmonic h: round(32768 * 2^-(falloff/100 * log2 h)), Q1.15
    function automatic logic [MASK_W-1:0] harmonic_weight(input int unsigned h,
                                                          input int unsigned falloff);
        logic [63:0] fac [17];
        logic [63:0] y;
        logic [63:0] lg;
        logic [63:0] e;
        logic [63:0] r;
        logic [31:0] k;
        logic [31:0] f;
        int unsigned n;
        int          i;
        fac[0] = 64'd1 << 30;
        for (i = 1; i <= 16; i++) begin
            fac[i] = isqrt64(fac[i-1] << 31);
        end
        n = 0;
        for (i = 0; i < 8; i++) begin
            if ((h >> (n + 1)) != 0) begin
                n = n + 1;
            end
        end
        y  = 64'(h) << (30 - n);
        lg = 64'(n) << 16;
        for (i = 1; i <= 16; i++) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
                y  = y >> 1;
                lg = lg | (64'd1 << (16 - i));
            end
        end
        e = (64'(falloff) * lg + 64'd50) / 64'd100;
        k = 32'(e >> 16);
        f = 32'(e & 64'h0000_0000_0000_FFFF);
        r = 64'd1 << 31;
        for (i = 1; i <= 16; i++) begin
            if (((f >> (16 - i)) & 32'd1) != 32'd0) begin
                r = (r * fac[i] + (64'd1 << 30)) >> 31;
            end
        end
        if (k > 32'd40) begin
            r = 64'd0;
        end else begin
            r = (r + (64'd1 << (15 + k))) >> (16 + k);
        end
        return (r > 64'd32768) ? MASK_ONE : MASK_W'(r);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/hcss_frac_div.sv
`default_nettype none

// Restoring divider: quot = floor(num * 2^16 / den) for num < den; num == den gives all ones.
// One quotient bit per cycle.
module hcss_frac_div #(
    parameter int W = 47
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [W-1:0]               num,
    input  wire logic [W-1:0]               den,
    output logic      [hcss_pkg::QUOT_W-1:0] quot,
    output logic                            done
);
    import hcss_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_W - 1);

    logic [W-1:0]      rem_reg;
    logic [W-1:0]      den_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         fits;
    logic [W-1:0] rem_next;

    always_comb begin
        shifted  = {rem_reg, 1'b0};
        diff     = shifted - {1'b0, den_reg};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (start) begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
            cnt_reg  <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/hcss_split.sv
`default_nettype none

// Splits a bin value by mask and by one minus mask, rounding half away
// from zero. One multiplier, one word per cycle, two-stage pipe.
module hcss_split (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic signed [hcss_pkg::VAL_W-1:0] re,
    input  wire logic signed [hcss_pkg::VAL_W-1:0] im,
    input  wire logic        [hcss_pkg::MASK_W-1:0] mask,
    output hcss_pkg::hcss_out_t                  res,
    output logic                                 done
);
    import hcss_pkg::*;

    localparam int SP_W = VAL_W + MASK_W;
    localparam logic [1:0] W_HARM_RE = 2'd0;
    localparam logic [1:0] W_HARM_IM = 2'd1;
    localparam logic [1:0] W_REST_RE = 2'd2;
    localparam logic [2:0] WORD_COUNT = 3'd4;
    localparam logic [SP_W-1:0] ROUND_HALF = SP_W'(16384);

    logic [2:0]       cnt_reg;
    logic             busy_reg;
    logic             pv_reg;
    logic             done_reg;
    logic [1:0]       idx_reg;
    logic             neg_reg;
    logic [SP_W-1:0]  prod_reg;
    hcss_out_t        res_reg;

    logic [1:0]              sel;
    logic signed [VAL_W-1:0] val;
    logic                    neg;
    logic [VAL_W-1:0]        mag;
    logic [MASK_W-1:0]       gain;
    logic [SP_W-1:0]         prod;
    logic [SP_W-1:0]         rounded;
    logic [VAL_W-1:0]        q;
    logic [VAL_W-1:0]        word;

    always_comb begin
        sel     = cnt_reg[1:0];
        // bit 0 picks the imaginary part, bit 1 the residual gain
        val     = sel[0] ? im : re;
        neg     = val[VAL_W-1];
        mag     = neg ? (~val + 1'b1) : val;
        gain    = sel[1] ? (MASK_ONE - mask) : mask;
        prod    = SP_W'(mag) * SP_W'(gain);
        rounded = prod_reg + ROUND_HALF;
        q       = rounded[VAL_W+14:15];
        word    = neg_reg ? (~q + 1'b1) : q;
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        pv_reg   <= 1'b0;
        if (start) begin
            busy_reg     <= 1'b1;
            cnt_reg      <= '0;
            res_reg.mask <= mask;
        end else if (busy_reg) begin
            if (cnt_reg != WORD_COUNT) begin
                prod_reg <= prod;
                neg_reg  <= neg;
                idx_reg  <= sel;
                pv_reg   <= 1'b1;
                cnt_reg  <= cnt_reg + 1'b1;
            end else begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            if (pv_reg) begin
                case (idx_reg)
                    W_HARM_RE: res_reg.harm_re <= word;
                    W_HARM_IM: res_reg.harm_im <= word;
                    W_REST_RE: res_reg.rest_re <= word;
                    default:   res_reg.rest_im <= word;
                endcase
            end
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/harmonic_comb_spectral_split.sv
`default_nettype none

// Channel   Direction  Handshake             Word
// s_        in         s_valid / s_ready     hcss_in_t  (fundamental, bin, value)
// m_        out        m_valid / m_ready     hcss_out_t (mask, harmonic, residual)
// cfg_      in         cfg_valid / cfg_ready index 0 sample_rate, 1 width_ratio
//
// One item at a time. A harmonic at or above Nyquist ends the walk; one outside
// its band passes the check, width, compare and next states, and one inside also
// waits on the shared fraction divider and takes the weight step. The split runs
// after the walk, through the split and wait states, before the output state.
// aresetn is synchronous; it restores sample_rate 48000 and width_ratio 3277
// and the block takes a word in the first cycle after. The result sits in an
// output register: the next word is taken while it waits, and the block only
// holds in its last state if the next result is done before the old one leaves.
module harmonic_comb_spectral_split #(
    parameter int FFT_POINTS   = 1024,
    parameter int HARMONICS    = 16,
    parameter int FALLOFF_X100 = 100
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire hcss_pkg::hcss_in_t                   s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output hcss_pkg::hcss_out_t                       m_data,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [hcss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [hcss_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import hcss_pkg::*;

    localparam int FFT_W  = $clog2(FFT_POINTS + 1);
    // harmonic frequency in 1/(16*FFT_POINTS) Hz, below Nyquist
    localparam int HNUM_W = NYQ_W + FFT_W;
    localparam int DIST_W = (HNUM_W > BNUM_W) ? HNUM_W : BNUM_W;
    // |B - H| * 2^16 and H * width_ratio
    localparam int PROD_W = DIST_W + WR_W;
    localparam int IDX_W  = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
    localparam logic [FFT_W-1:0] FFT_K    = FFT_W'(FFT_POINTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HARMONICS - 1);
    localparam logic [31:0]      ROUND_Q16 = 32'd32768;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,   // Nyquist test, harmonic frequency times FFT size
        S_WIDTH,   // band half-width and distance
        S_CMP,     // in band? start the divider
        S_DIV,
        S_WEIGHT,  // weight times triangle, running maximum
        S_NEXT,
        S_SPLIT,
        S_WAIT,
        S_OUT
    } state_t;

    // weight table, built at elaboration
    logic [MASK_W-1:0] weight_rom [HARMONICS];

    for (genvar gi = 0; gi < HARMONICS; gi++) begin : g_rom
        assign weight_rom[gi] = harmonic_weight(gi + 1, FALLOFF_X100);
    end

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        h_reg, h_next;
    logic [HF_W-1:0]         hf_reg, hf_next;
    logic [FUND_W-1:0]       fund_reg, fund_next;
    logic [BNUM_W-1:0]       bnum_reg, bnum_next;
    logic [HNUM_W-1:0]       hnum_reg, hnum_next;
    logic [DIST_W-1:0]       dist_reg, dist_next;
    logic [PROD_W-1:0]       d_reg, d_next;
    logic [MASK_W-1:0]       mask_reg, mask_next;
    logic signed [VAL_W-1:0] re_reg, re_next;
    logic signed [VAL_W-1:0] im_reg, im_next;
    logic [SR_W-1:0]         sample_rate_reg, sample_rate_next;
    logic [WR_W-1:0]         width_ratio_reg, width_ratio_next;
    logic                    m_valid_reg, m_valid_next;
    hcss_out_t               m_data_reg, m_data_next;

    logic [BIN_W+SR_W-1:0] bin_sr;
    logic [HF_W-1:0]       nyq;
    logic [HNUM_W-1:0]     hnum_prod;
    logic [PROD_W-1:0]     d_prod;
    logic [DIST_W-1:0]     bext;
    logic [DIST_W-1:0]     hext;
    logic [DIST_W-1:0]     dist_abs;
    logic [PROD_W-1:0]     a_val;
    logic [31:0]           wprod;
    logic [MASK_W-1:0]     contrib;
    logic [MASK_W-1:0]     mask_clamped;

    logic                  div_start;
    logic [PROD_W-1:0]     div_num;
    logic [QUOT_W-1:0]     div_quot;
    logic                  div_done;
    logic                  split_start;
    hcss_out_t             split_res;
    logic                  split_done;

    always_comb begin
        bin_sr       = (BIN_W+SR_W)'(s_data.bin_index) * (BIN_W+SR_W)'(sample_rate_reg);
        nyq          = HF_W'({sample_rate_reg, 3'b000});
        hnum_prod    = HNUM_W'(hf_reg[NYQ_W-1:0]) * HNUM_W'(FFT_K);
        d_prod       = PROD_W'(hnum_reg) * PROD_W'(width_ratio_reg);
        bext         = DIST_W'(bnum_reg);
        hext         = DIST_W'(hnum_reg);
        dist_abs     = (bext > hext) ? (bext - hext) : (hext - bext);
        a_val        = {dist_reg, {WR_W{1'b0}}};
        wprod        = 32'(weight_rom[h_reg]) * 32'(div_quot) + ROUND_Q16;
        contrib      = wprod[31:16];
        mask_clamped = (mask_reg > MASK_ONE) ? MASK_ONE : mask_reg;
        div_start    = (state_reg == S_CMP) && (a_val < d_reg);
        div_num      = d_reg - a_val;
        split_start  = (state_reg == S_SPLIT);
    end

    always_comb begin
        state_next       = state_reg;
        h_next           = h_reg;
        hf_next          = hf_reg;
        fund_next        = fund_reg;
        bnum_next        = bnum_reg;
        hnum_next        = hnum_reg;
        dist_next        = dist_reg;
        d_next           = d_reg;
        mask_next        = mask_reg;
        re_next          = re_reg;
        im_next          = im_reg;
        sample_rate_next = sample_rate_reg;
        width_ratio_next = width_ratio_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_SAMPLE_RATE: sample_rate_next = cfg_data[SR_W-1:0];
                CFG_WIDTH_RATIO: width_ratio_next = cfg_data[WR_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    fund_next  = s_data.fundamental;
                    hf_next    = HF_W'(s_data.fundamental);
                    bnum_next  = {bin_sr, 4'b0000};
                    re_next    = s_data.bin_re;
                    im_next    = s_data.bin_im;
                    h_next     = '0;
                    mask_next  = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (hf_reg >= nyq) begin
                    state_next = S_SPLIT;
                end else begin
                    hnum_next  = hnum_prod;
                    state_next = S_WIDTH;
                end
            end
            S_WIDTH: begin
                d_next     = d_prod;
                dist_next  = dist_abs;
                state_next = S_CMP;
            end
            S_CMP: begin
                state_next = (a_val < d_reg) ? S_DIV : S_NEXT;
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_WEIGHT;
                end
            end
            S_WEIGHT: begin
                if (contrib > mask_reg) begin
                    mask_next = contrib;
                end
                state_next = S_NEXT;
            end
            S_NEXT: begin
                if (h_reg == LAST_IDX) begin
                    state_next = S_SPLIT;
                end else begin
                    h_next     = h_reg + 1'b1;
                    hf_next    = hf_reg + HF_W'(fund_reg);
                    state_next = S_CHECK;
                end
            end
            S_SPLIT: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (split_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = split_res;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        state_reg       <= state_next;
        h_reg           <= h_next;
        hf_reg          <= hf_next;
        fund_reg        <= fund_next;
        bnum_reg        <= bnum_next;
        hnum_reg        <= hnum_next;
        dist_reg        <= dist_next;
        d_reg           <= d_next;
        mask_reg        <= mask_next;
        re_reg          <= re_next;
        im_reg          <= im_next;
        sample_rate_reg <= sample_rate_next;
        width_ratio_reg <= width_ratio_next;
        m_valid_reg     <= m_valid_next;
        m_data_reg      <= m_data_next;
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_valid_reg     <= 1'b0;
            sample_rate_reg <= SAMPLE_RATE_RESET;
            width_ratio_reg <= WIDTH_RATIO_RESET;
        end
    end

    // shared fraction divider: triangle value (D - A) / D in Q0.16
    hcss_frac_div #(
        .W(PROD_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (d_reg),
        .quot    (div_quot),
        .done    (div_done)
    );

    hcss_split u_split (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (split_start),
        .re      (re_reg),
        .im      (im_reg),
        .mask    (mask_clamped),
        .res     (split_res),
        .done    (split_done)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/hcss_checker.sv
`default_nettype none

module hcss_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire hcss_pkg::hcss_out_t m_data
);
    import hcss_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // one item in flight: busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again while busy");

    a_zero_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.mask == '0) |->
            (m_data.harm_re == '0) && (m_data.harm_im == '0))
        else $error("harmonic part nonzero under zero mask");

    a_full_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.mask == MASK_ONE) |->
            (m_data.rest_re == '0) && (m_data.rest_im == '0))
        else $error("residual part nonzero under full mask");

    a_mask_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.mask <= MASK_ONE))
        else $error("mask above one");

endmodule

bind harmonic_comb_spectral_split hcss_checker u_checker (.*);

`default_nettype wire
